>>> design/rgos_pkg.sv
// ----------------------------------------------------------------------------
// rgos_pkg
// Shared types, constants and saturating helpers for the radial GP stencil.
// ----------------------------------------------------------------------------
package rgos_pkg;

	localparam int QW         = 48;                  // Q24.24 port width
	localparam int HW         = 47;                  // unsigned register width
	localparam int FRAC       = 24;                  // fraction bits
	localparam int IW         = 62;                  // intermediate width
	localparam int MH         = IW / 2;              // multiplier half width
	localparam int QB         = 2 * FRAC + 1;        // reciprocal quotient bits
	localparam int MAX_POINTS = 1024;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int PIDX_W     = 10;                  // point_index port width
	localparam int CFG_IW     = 3;

	typedef logic signed [IW-1:0] iq_t;
	typedef logic signed [QW-1:0] q_t;

	localparam iq_t IMAX = {1'b0, {(IW-1){1'b1}}};
	localparam iq_t IMIN = {1'b1, {(IW-1){1'b0}}};
	localparam q_t  QMAX = {1'b0, {(QW-1){1'b1}}};
	localparam q_t  QMIN = {1'b1, {(QW-1){1'b0}}};

	typedef struct packed {
		iq_t  v;
		logic clip;
	} iq_res_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic clip;
	} mul_rsp_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_rsp_t;

	typedef enum logic [CFG_IW-1:0] {
		REG_STEP    = 3'd0,
		REG_LEFT    = 3'd1,
		REG_KINV    = 3'd2,
		REG_COUPLE  = 3'd3,
		REG_MU      = 3'd4
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_OFF,
		ST_RAD,
		ST_HR,
		ST_DIV,
		ST_RR,
		ST_CTR,
		ST_PRV,
		ST_NXT,
		ST_CC,
		ST_CCC,
		ST_CPL,
		ST_MU,
		ST_OUT
	} state_t;

	// a + b or a - b, clipped to the intermediate range
	function automatic iq_res_t q_add(iq_t a, iq_t b, logic sub);
		logic signed [IW:0] ea;
		logic signed [IW:0] eb;
		logic signed [IW:0] s;
		iq_res_t r;
		ea = {a[IW-1], a};
		eb = {b[IW-1], b};
		s  = sub ? ea - eb : ea + eb;
		r.clip = s[IW] != s[IW-1];
		r.v    = r.clip ? (s[IW] ? IMIN : IMAX) : s[IW-1:0];
		return r;
	endfunction

	// halving, rounds toward minus infinity
	function automatic iq_t q_half(iq_t a);
		return a >>> 1;
	endfunction

	function automatic iq_t ext_s(q_t a);
		return {{(IW-QW){a[QW-1]}}, a};
	endfunction

	function automatic iq_t ext_u(logic [HW-1:0] a);
		return {{(IW-HW){1'b0}}, a};
	endfunction

endpackage

>>> design/radial_gp_operator_stencil_top.sv
// ----------------------------------------------------------------------------
// radial_gp_operator_stencil_top
// Streaming radial Gross-Pitaevskii finite-difference operator, Q24.24.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  cfg     | in        | cfg_we             | cfg_index, cfg_data
//  in      | in        | in_valid/in_stall  | sample, final_req
//  out     | out       | out_valid/out_stall| result, point_index, run_end,
//          |           |                    | saturated
//
//  Each result point runs through one shared multiplier (9 products) and a
//  bit-serial divider. An input transaction gives zero, one or two points,
//  so it holds in_stall while those points are evaluated, plus any time
//  spent waiting on out_stall.
//  One output register lets the next point start while a result waits.
//  Reset (arst_n, async low) clears the window, the sequencer and out_valid.
// ----------------------------------------------------------------------------
module radial_gp_operator_stencil_top import rgos_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [QW-1:0]     cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  q_t                sample,
	input  logic              final_req,
	output logic              out_valid,
	input  logic              out_stall,
	output q_t                result,
	output logic [PIDX_W-1:0] point_index,
	output logic              run_end,
	output logic              saturated
);

	// configuration
	logic [HW-1:0] step_q, kinv_q;
	q_t            left_q, couple_q, mu_q;

	// sample window
	q_t               older_q, newer_q;
	logic [IDX_W-1:0] next_q;
	logic             have_q;

	// point being evaluated, and the pending second point of a run end
	logic [IDX_W-1:0] pt_idx_q, idx2_q;
	q_t               pt_p_q, pt_c_q, pt_n_q, p2_q, c2_q;
	logic             pt_last_q, em2_q;

	// working registers
	iq_t    off_q, r_q, hr_q, d_q, t_q, y_q;
	logic   clip_q, wait_q;
	state_t state_q, state_nx;

	// output register
	logic              out_valid_q, run_end_q, sat_q;
	q_t                result_q;
	logic [PIDX_W-1:0] pidx_q;

	// shared units
	logic     mul_start, div_start;
	iq_t      mul_a, mul_b, mul_res, div_res;
	mul_rsp_t mul_rsp;
	div_rsp_t div_rsp;
	logic     op_clip;

	logic              in_acc, out_load;
	logic [IDX_W-1:0]  k_in;
	logic              fin_in;
	logic [IDX_W+HW:0] span;
	logic              is_mul;
	iq_res_t           rad_sum, y_sum, op_sum;
	logic              y48_clip;
	q_t                y48;

	rgos_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.res    (mul_res),
		.rsp    (mul_rsp)
	);

	rgos_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.den    (hr_q),
		.res    (div_res),
		.rsp    (div_rsp)
	);

	assign in_acc = in_valid && !in_stall;
	assign k_in   = have_q ? next_q : '0;
	assign fin_in = final_req || (k_in >= IDX_W'(MAX_POINTS - 1));

	// radius offset (2i+1)*h/2, far below the intermediate limit
	assign span    = {pt_idx_q, 1'b1} * step_q;
	assign rad_sum = q_add(ext_s(left_q), iq_t'(span >> 1), 1'b0);

	assign is_mul = state_q == ST_HR  || state_q == ST_RR  || state_q == ST_CTR ||
	                state_q == ST_PRV || state_q == ST_NXT || state_q == ST_CC  ||
	                state_q == ST_CCC || state_q == ST_CPL || state_q == ST_MU;

	// accumulate: coupling term adds, the others subtract
	assign y_sum = q_add(y_q, mul_res, state_q != ST_CPL);

	assign y48_clip = (y_q > ext_s(QMAX)) || (y_q < ext_s(QMIN));
	assign y48      = y48_clip ? (y_q[IW-1] ? QMIN : QMAX) : y_q[QW-1:0];

	assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: if (in_acc && (have_q || fin_in)) state_nx = ST_OFF;
			ST_OFF:  state_nx = ST_RAD;
			ST_RAD:  state_nx = ST_HR;
			ST_HR:   if (mul_rsp.done) state_nx = ST_DIV;
			ST_DIV:  if (hr_q == '0 || div_rsp.done) state_nx = ST_RR;
			ST_RR:   if (mul_rsp.done) state_nx = ST_CTR;
			ST_CTR:  if (mul_rsp.done) state_nx = ST_PRV;
			ST_PRV:  if (mul_rsp.done) state_nx = ST_NXT;
			ST_NXT:  if (mul_rsp.done) state_nx = ST_CC;
			ST_CC:   if (mul_rsp.done) state_nx = ST_CCC;
			ST_CCC:  if (mul_rsp.done) state_nx = ST_CPL;
			ST_CPL:  if (mul_rsp.done) state_nx = ST_MU;
			ST_MU:   if (mul_rsp.done) state_nx = ST_OUT;
			ST_OUT:  if (out_load) state_nx = em2_q ? ST_OFF : ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	// operand selection and unit control
	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		op_sum  = '0;
		unique case (state_q)
			ST_HR:  begin mul_a = ext_u(step_q); mul_b = r_q; end
			ST_RR:  begin mul_a = r_q; mul_b = r_q; end
			ST_CTR: begin
				op_sum = q_add(ext_u(kinv_q), q_half(t_q), 1'b0);
				mul_a  = ext_s(pt_c_q);
				mul_b  = op_sum.v;
			end
			ST_PRV: begin
				op_sum = q_add(ext_u(kinv_q), d_q, 1'b1);
				mul_a  = ext_s(pt_p_q);
				mul_b  = q_half(op_sum.v);
			end
			ST_NXT: begin
				op_sum = q_add(ext_u(kinv_q), d_q, 1'b0);
				mul_a  = ext_s(pt_n_q);
				mul_b  = q_half(op_sum.v);
			end
			ST_CC:  begin mul_a = ext_s(pt_c_q); mul_b = ext_s(pt_c_q); end
			ST_CCC: begin mul_a = t_q; mul_b = ext_s(pt_c_q); end
			ST_CPL: begin mul_a = ext_s(couple_q); mul_b = t_q; end
			ST_MU:  begin mul_a = ext_s(mu_q); mul_b = ext_s(pt_c_q); end
			default: ;
		endcase
		mul_start = is_mul && !wait_q;
		div_start = (state_q == ST_DIV) && !wait_q && (hr_q != '0);
		op_clip   = mul_start && op_sum.clip;
		in_stall  = state_q != ST_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wait_q      <= 1'b0;
			out_valid_q <= 1'b0;
			have_q      <= 1'b0;
			next_q      <= '0;
			older_q     <= '0;
			newer_q     <= '0;
			em2_q       <= 1'b0;
			step_q      <= HW'(1) << FRAC;
			kinv_q      <= HW'(1) << FRAC;
			left_q      <= '0;
			couple_q    <= '0;
			mu_q        <= '0;
		end else begin
			state_q <= state_nx;

			if (mul_start || div_start)
				wait_q <= 1'b1;
			else if (mul_rsp.done || div_rsp.done)
				wait_q <= 1'b0;

			if (cfg_we) begin
				unique case (cfg_index)
					REG_STEP:   step_q   <= cfg_data[HW-1:0];
					REG_LEFT:   left_q   <= cfg_data;
					REG_KINV:   kinv_q   <= cfg_data[HW-1:0];
					REG_COUPLE: couple_q <= cfg_data;
					REG_MU:     mu_q     <= cfg_data;
					default: ;
				endcase
			end

			// window update happens at acceptance
			if (in_acc) begin
				em2_q <= have_q && fin_in;
				if (fin_in) begin
					older_q <= '0;
					newer_q <= '0;
					next_q  <= '0;
					have_q  <= 1'b0;
				end else begin
					older_q <= have_q ? newer_q : sample;
					newer_q <= sample;
					next_q  <= k_in + 1'b1;
					have_q  <= 1'b1;
				end
			end else if (out_load && em2_q) begin
				em2_q <= 1'b0;
			end

			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_acc) begin
			clip_q <= 1'b0;
			p2_q   <= newer_q;
			c2_q   <= sample;
			idx2_q <= k_in;
			if (have_q) begin
				pt_idx_q  <= k_in - 1'b1;
				pt_p_q    <= older_q;
				pt_c_q    <= newer_q;
				pt_n_q    <= sample;
				pt_last_q <= 1'b0;
			end else begin
				pt_idx_q  <= k_in;
				pt_p_q    <= sample;
				pt_c_q    <= sample;
				pt_n_q    <= sample;
				pt_last_q <= 1'b1;
			end
		end else if (out_load && em2_q) begin
			clip_q    <= 1'b0;
			pt_idx_q  <= idx2_q;
			pt_p_q    <= p2_q;
			pt_c_q    <= c2_q;
			pt_n_q    <= c2_q;
			pt_last_q <= 1'b1;
		end else begin
			if (op_clip || (mul_rsp.done && mul_rsp.clip))
				clip_q <= 1'b1;
			unique case (state_q)
				ST_OFF: off_q <= iq_t'(span >> 1);
				ST_RAD: begin
					r_q <= q_add(ext_s(left_q), off_q, 1'b0).v;
					if (rad_sum.clip) clip_q <= 1'b1;
				end
				ST_HR:  if (mul_rsp.done) hr_q <= mul_res;
				ST_DIV: begin
					if (hr_q == '0) begin
						d_q    <= IMAX;
						clip_q <= 1'b1;
					end else if (div_rsp.done) begin
						d_q <= div_res;
					end
				end
				ST_RR, ST_CC, ST_CCC: if (mul_rsp.done) t_q <= mul_res;
				ST_CTR: if (mul_rsp.done) y_q <= mul_res;
				ST_PRV, ST_NXT, ST_CPL, ST_MU: begin
					if (mul_rsp.done) begin
						y_q <= y_sum.v;
						if (y_sum.clip) clip_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end

		if (out_load) begin
			result_q  <= y48;
			pidx_q    <= PIDX_W'(pt_idx_q);
			run_end_q <= pt_last_q;
			sat_q     <= clip_q || y48_clip;
		end
	end

	assign out_valid   = out_valid_q;
	assign result      = result_q;
	assign point_index = pidx_q;
	assign run_end     = run_end_q;
	assign saturated   = sat_q;

	// shared multiplier is never restarted while a product is in flight
	a_mul_free: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |-> !mul_rsp.busy && !div_rsp.busy)
		else $error("multiplier started while busy");

	// a point never overwrites a result still waiting downstream
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(result) && $stable(point_index))
		else $error("held result changed");

	// a transaction that completes a point starts the sequencer
	a_seq_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && have_q |=> state_q == ST_OFF)
		else $error("sequencer did not start");

	// divider only runs in its own step
	a_div_step: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.busy |-> state_q == ST_DIV)
		else $error("divider busy outside divide step");

endmodule

>>> design/rgos_mul.sv
// ----------------------------------------------------------------------------
// rgos_mul
// Shared Q24.24 multiplier: four half-width partial products, floor
// rounding and saturation to the intermediate range.
// ----------------------------------------------------------------------------
module rgos_mul import rgos_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  iq_t      a,
	input  iq_t      b,
	output iq_t      res,
	output mul_rsp_t rsp
);

	logic [IW-1:0]   ma_q, mb_q;
	logic            neg_q;
	logic [2*IW-1:0] acc_q;
	logic [2*MH-1:0] pp_s1;
	logic [1:0]      sh_s1;
	logic [2:0]      cnt_q;
	logic            busy_q, done_q, clip_q;
	iq_t             res_q;

	logic [IW-1:0]   ua, ub;
	logic [MH-1:0]   opa, opb;
	logic [1:0]      sh;
	logic [2*IW-1:0] ppx;
	logic [63:0]     qv;
	logic [64:0]     qn;
	logic            hi_ovf, rnd;
	iq_t             fin_v;
	logic            fin_c;

	assign ua = a[IW-1] ? (~a + 1'b1) : a;
	assign ub = b[IW-1] ? (~b + 1'b1) : b;

	always_comb begin
		unique case (cnt_q[1:0])
			2'd0: begin opa = ma_q[MH-1:0];  opb = mb_q[MH-1:0];  sh = 2'd0; end
			2'd1: begin opa = ma_q[MH-1:0];  opb = mb_q[IW-1:MH]; sh = 2'd1; end
			2'd2: begin opa = ma_q[IW-1:MH]; opb = mb_q[MH-1:0];  sh = 2'd1; end
			default: begin opa = ma_q[IW-1:MH]; opb = mb_q[IW-1:MH]; sh = 2'd2; end
		endcase
	end

	always_comb begin
		unique case (sh_s1)
			2'd0:    ppx = (2*IW)'(pp_s1);
			2'd1:    ppx = (2*IW)'(pp_s1) << MH;
			default: ppx = (2*IW)'(pp_s1) << (2 * MH);
		endcase
	end

	// final rounding and clipping
	always_comb begin
		hi_ovf = |acc_q[2*IW-1:FRAC+64];
		qv     = acc_q[FRAC+63:FRAC];
		rnd    = neg_q && (|acc_q[FRAC-1:0]);
		qn     = {1'b0, qv} + 65'(rnd);
		fin_c  = 1'b0;
		fin_v  = IMAX;
		if (neg_q) begin
			if (hi_ovf || qn > (65'(1) << (IW - 1))) begin
				fin_c = 1'b1;
				fin_v = IMIN;
			end else begin
				fin_v = ~qn[IW-1:0] + 1'b1;
			end
		end else begin
			if (hi_ovf || qv > 64'(IMAX)) begin
				fin_c = 1'b1;
				fin_v = IMAX;
			end else begin
				fin_v = qv[IW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 3'd5) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ma_q  <= ua;
			mb_q  <= ub;
			neg_q <= a[IW-1] != b[IW-1];
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q < 3'd4) begin
				pp_s1 <= opa * opb;
				sh_s1 <= sh;
			end
			if (cnt_q >= 3'd1 && cnt_q <= 3'd4)
				acc_q <= acc_q + ppx;
			if (cnt_q == 3'd5) begin
				res_q  <= fin_v;
				clip_q <= fin_c;
			end
		end
	end

	assign res      = res_q;
	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.clip = clip_q;

endmodule

>>> design/rgos_div.sv
// ----------------------------------------------------------------------------
// rgos_div
// Restoring divider for D = 2^48 / h*r, one quotient bit per cycle,
// truncating toward zero.
// ----------------------------------------------------------------------------
module rgos_div import rgos_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  iq_t      den,
	output iq_t      res,
	output div_rsp_t rsp
);

	localparam int CW = $clog2(QB);

	logic [IW-1:0] den_q;
	logic [IW-1:0] rem_q;
	logic [QB-1:0] quo_q;
	logic          neg_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;

	logic [IW:0]   trial;
	logic          fits;
	iq_t           qx;

	assign trial = {rem_q, cnt_q == '0};
	assign fits  = trial >= {1'b0, den_q};
	assign qx    = iq_t'(quo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(QB - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den[IW-1] ? (~den + 1'b1) : den;
			neg_q <= den[IW-1];
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? IW'(trial - {1'b0, den_q}) : trial[IW-1:0];
			quo_q <= {quo_q[QB-2:0], fits};
		end
	end

	assign res      = neg_q ? -qx : qx;
	assign rsp.busy = busy_q;
	assign rsp.done = done_q;

endmodule

>>> sim/radial_gp_operator_stencil_top_tb.sv
// ----------------------------------------------------------------------------
// radial_gp_operator_stencil_top_tb
// Self-checking bench for the radial GP stencil. Sample streams go in over a
// valid/stall channel with random gaps. Every accepted transaction runs
// through a fixed-point operator model kept in this file. The model's
// expected points are queued and compared field by field with each accepted
// output transaction. A directed table comes first, then an overlong run, then
// random runs under randomly chosen register settings.
// ----------------------------------------------------------------------------
module radial_gp_operator_stencil_top_tb;
	import rgos_pkg::*;

	localparam longint ONE      = 64'sd1 << 24;     // 1.0 in Q24.24
	localparam longint I_MAX    = 64'sh1FFFFFFFFFFFFFFF;
	localparam longint I_MIN    = -I_MAX - 1;
	localparam longint Q_MAX    = 64'sh7FFFFFFFFFFF;
	localparam longint Q_MIN    = -Q_MAX - 1;
	localparam longint H_MAX    = 64'sh7FFFFFFFFFFF; // largest 47-bit register
	localparam int     N_ITEMS  = 1850;
	localparam int     SETTLE   = 400;                // > two points of latency
	localparam int     WD_LIMIT = 20000;

	typedef struct {
		q_t               result;
		logic [PIDX_W-1:0] pidx;
		logic             last;
		logic             sat;
	} point_t;

	// directed row: optional register write first, then one input transaction
	typedef struct {
		bit     wr;
		cfg_reg_t reg_id;
		longint wval;
		longint smp;
		bit     fin;
		bit     typed;    // override the predicted result and saturated flag
		longint tres;
		bit     tsat;
	} row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [CFG_IW-1:0] cfg_index = '0;
	logic [QW-1:0]     cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	q_t                sample = '0;
	logic              final_req = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	q_t                result;
	logic [PIDX_W-1:0] point_index;
	logic              run_end;
	logic              saturated;

	radial_gp_operator_stencil_top dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ---------------------------------------------------------------- model
	// register copies
	longint h_reg = ONE, left_reg = 0, kinv_reg = ONE, g_reg = 0, mu_reg = 0;
	// stream window
	longint win_old = 0, win_new = 0;
	int     idx_next = 0;
	bit     win_full = 0;
	bit     clipped;

	point_t pending_pts[$];
	int     errors = 0;
	int     quiet_cycles = 0;

	function automatic longint sat_to(longint v, longint lo, longint hi);
		if (v > hi) begin
			clipped = 1; return hi;
		end
		if (v < lo) begin
			clipped = 1; return lo;
		end
		return v;
	endfunction

	function automatic longint add_i(longint a, longint b);
		return sat_to(a + b, I_MIN, I_MAX);
	endfunction

	function automatic longint half_i(longint v);
		return v >>> 1;
	endfunction

	function automatic bit [63:0] abs_u(longint v);
		return v < 0 ? 64'd0 - 64'(v) : 64'(v);
	endfunction

	// Q24.24 product, floor rounding, clipped to the intermediate range
	function automatic longint mul_i(longint a, longint b);
		bit [127:0] p;
		bit [63:0]  q;
		bit         neg;
		p   = {64'd0, abs_u(a)} * {64'd0, abs_u(b)};
		neg = (a < 0) != (b < 0);
		if (p[127:88] != 0) begin
			clipped = 1;
			return neg ? I_MIN : I_MAX;
		end
		q = p[87:24];
		if (neg) begin
			if (p[23:0] != 0) q = q + 1;
			if (q > 64'(I_MAX) + 1) begin
				clipped = 1; return I_MIN;
			end
			return -longint'(q);
		end
		if (q > 64'(I_MAX)) begin
			clipped = 1; return I_MAX;
		end
		return longint'(q);
	endfunction

	// operator at grid index ix with left/centre/right samples
	function automatic longint gp_point(int ix, longint p, longint c, longint n);
		bit [63:0] off;
		longint r, hr, d, y, qd;
		off = ((64'(ix) * 2 + 1) * 64'(h_reg)) >> 1;
		if (off > 64'(I_MAX)) begin
			clipped = 1; off = 64'(I_MAX);
		end
		r  = add_i(left_reg, longint'(off));
		hr = mul_i(h_reg, r);
		if (hr == 0) begin
			clipped = 1;
			d = I_MAX;           // zero radius: treat 1/(h*r) as huge
		end else begin
			qd = longint'((64'd1 << 48) / abs_u(hr));
			d  = hr < 0 ? -qd : qd;
		end
		y = mul_i(c, add_i(kinv_reg, half_i(mul_i(r, r))));
		y = add_i(y, -mul_i(p, half_i(add_i(kinv_reg, -d))));
		y = add_i(y, -mul_i(n, half_i(add_i(kinv_reg, d))));
		y = add_i(y, mul_i(g_reg, mul_i(mul_i(c, c), c)));
		y = add_i(y, -mul_i(mu_reg, c));
		return sat_to(y, Q_MIN, Q_MAX);
	endfunction

	function automatic void queue_point(int ix, longint p, longint c, longint n,
		bit last);
		point_t e;
		clipped  = 0;
		e.result = q_t'(gp_point(ix, p, c, n));
		e.pidx   = ix[PIDX_W-1:0];
		e.last   = last;
		e.sat    = clipped;
		pending_pts.push_back(e);
	endfunction

	// one accepted input transaction: slide window, queue the points it frees
	function automatic void take_sample(q_t s_in, logic f_in);
		longint s;
		int     k;
		bit     fin;
		s   = longint'(s_in);
		k   = win_full ? idx_next : 0;
		fin = f_in || k >= MAX_POINTS - 1;   // overlong runs end on their own
		if (!win_full) begin
			win_old = s;
			win_new = s;
		end else begin
			queue_point(k - 1, win_old, win_new, s, 0);
			win_old = win_new;
			win_new = s;
		end
		if (fin) begin
			queue_point(k, win_old, s, s, 1);
			win_old  = 0;
			win_new  = 0;
			idx_next = 0;
			win_full = 0;
		end else begin
			idx_next = k + 1;
			win_full = 1;
		end
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("ERROR t=%0t %s: got %0h want %0h", $time, what, got, want);
		errors++;
	endtask

	// ------------------------------------------------------------- monitors
	// Inputs/outputs are sampled at the rising edge (pre-edge values).
	always @(posedge clk) begin
		point_t e;
		bit     moved;
		if (arst_n) begin
			moved = cfg_we;
			if (in_valid && !in_stall) begin
				take_sample(sample, final_req);
				moved = 1;
			end
			if (out_valid && !out_stall) begin
				moved = 1;
				if (pending_pts.size() == 0) begin
					report("unexpected output transaction", result, 0);
				end else begin
					e = pending_pts.pop_front();
					if (result !== e.result) report("result", result, e.result);
					if (point_index !== e.pidx) report("point_index", point_index, e.pidx);
					if (run_end !== e.last) report("run_end", run_end, e.last);
					if (saturated !== e.sat) report("saturated", saturated, e.sat);
				end
			end
			quiet_cycles <= moved ? 0 : quiet_cycles + 1;
		end
	end

	// No progress for too long: the block hung.
	always @(posedge clk) begin
		if (quiet_cycles >= WD_LIMIT) begin
			$display("radial_gp_operator_stencil_top: mismatch");
			$finish;
		end
	end

	// ------------------------------------------------------- output stalls
	int  stall_left = 0;
	bit  stall_on = 1;      // toggles so some stretches never stall

	always @(negedge clk) begin
		if ($urandom_range(0, 499) == 0) stall_on = !stall_on;
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (stall_on && $urandom_range(0, 3) == 0) begin
			stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
			                                         : $urandom_range(0, 3);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// ------------------------------------------------------------- drivers
	function automatic int pick_gap();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 65) return 0;
		if (sel < 95) return $urandom_range(1, 3);
		return $urandom_range(15, 50);
	endfunction

	// Present one transaction and hold it until accepted; ends at a falling edge.
	task automatic send_sample(longint s, bit fin);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample    <= q_t'(s);
		final_req <= fin;
		in_valid  <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// Sender pause: every expected point back, then the block's own latency.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_pts.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// Register write; only called once the block is drained.
	task automatic write_reg(cfg_reg_t id, longint v);
		cfg_we    <= 1'b1;
		cfg_index <= id;
		cfg_data  <= v[QW-1:0];
		case (id)
			REG_STEP:   h_reg    = v & H_MAX;
			REG_LEFT:   left_reg = longint'(q_t'(v));
			REG_KINV:   kinv_reg = v & H_MAX;
			REG_COUPLE: g_reg    = longint'(q_t'(v));
			REG_MU:     mu_reg   = longint'(q_t'(v));
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic longint rand_q();
		return longint'(q_t'({$urandom, $urandom}));
	endfunction

	// mostly modest magnitudes, sometimes the full Q24.24 range or an edge
	function automatic longint rand_sample();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 75) return longint'($urandom_range(0, 32'h1000_0000)) - 64'sh0800_0000;
		if (sel < 92) return rand_q();
		if (sel < 96) return Q_MAX;
		return Q_MIN;
	endfunction

	task automatic random_setup();
		int sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0: write_reg(REG_STEP, 1);
			1: write_reg(REG_STEP, H_MAX);
			2: write_reg(REG_STEP, {$urandom, $urandom} & H_MAX);
			default: write_reg(REG_STEP, $urandom_range(32'h0004_0000, 32'h0400_0000));
		endcase
		sel = $urandom_range(0, 9);
		case (sel)
			0: write_reg(REG_LEFT, Q_MIN);
			1: write_reg(REG_LEFT, Q_MAX);
			2: write_reg(REG_LEFT, rand_q());
			3: write_reg(REG_LEFT, -(h_reg >>> 1));   // first radius lands on zero
			default: write_reg(REG_LEFT, longint'($urandom_range(0, 32'h0800_0000))
			                             - 64'sh0400_0000);
		endcase
		sel = $urandom_range(0, 9);
		case (sel)
			0: write_reg(REG_KINV, 0);
			1: write_reg(REG_KINV, H_MAX);
			2: write_reg(REG_KINV, {$urandom, $urandom} & H_MAX);
			default: write_reg(REG_KINV, $urandom_range(0, 32'h4000_0000));
		endcase
		sel = $urandom_range(0, 9);
		case (sel)
			0: write_reg(REG_COUPLE, Q_MIN);
			1: write_reg(REG_COUPLE, Q_MAX);
			2: write_reg(REG_COUPLE, rand_q());
			default: write_reg(REG_COUPLE, longint'($urandom_range(0, 32'h0400_0000))
			                               - 64'sh0200_0000);
		endcase
		sel = $urandom_range(0, 9);
		case (sel)
			0: write_reg(REG_MU, Q_MIN);
			1: write_reg(REG_MU, Q_MAX);
			2: write_reg(REG_MU, rand_q());
			default: write_reg(REG_MU, longint'($urandom_range(0, 32'h0800_0000))
			                           - 64'sh0400_0000);
		endcase
	endtask

	// --------------------------------------------------------------- table
	// Typed rows: zero stream gives zero; a zero first radius flags
	// saturation. Full-scale single samples are left to the model.
	row_t plan[] = '{
		'{0, REG_STEP,   0,           0,            1, 1, 0,     0},
		'{0, REG_STEP,   0,           Q_MAX,        1, 0, 0,     0},
		'{0, REG_STEP,   0,           Q_MIN,        1, 0, 0,     0},
		'{0, REG_STEP,   0,           ONE,          0, 0, 0,     0},
		'{0, REG_STEP,   0,           -ONE,         0, 0, 0,     0},
		'{0, REG_STEP,   0,           ONE / 2,      0, 0, 0,     0},
		'{0, REG_STEP,   0,           2 * ONE,      0, 0, 0,     0},
		'{0, REG_STEP,   0,           3 * ONE,      1, 0, 0,     0},
		'{1, REG_LEFT,   -ONE / 2,    0,            1, 1, 0,     1},
		'{0, REG_STEP,   0,           ONE,          0, 0, 0,     0},
		'{0, REG_STEP,   0,           -2 * ONE,     1, 0, 0,     0},
		'{1, REG_COUPLE, ONE,         2 * ONE,      0, 0, 0,     0},
		'{0, REG_STEP,   0,           -3 * ONE,     1, 0, 0,     0},
		'{1, REG_MU,     -5 * ONE / 2, 3 * ONE / 2, 1, 0, 0,     0},
		'{1, REG_STEP,   H_MAX,       ONE,          0, 0, 0,     0},
		'{0, REG_STEP,   0,           2 * ONE,      1, 0, 0,     0},
		'{1, REG_KINV,   H_MAX,       7 * ONE,      1, 0, 0,     0},
		'{1, REG_STEP,   1,           ONE,          0, 0, 0,     0},
		'{1, REG_KINV,   0,           ONE,          1, 0, 0,     0},
		'{1, REG_LEFT,   Q_MIN,       5 * ONE,      1, 0, 0,     0},
		'{1, REG_LEFT,   Q_MAX,       -ONE,         0, 0, 0,     0},
		'{1, REG_COUPLE, Q_MIN,       ONE,          1, 0, 0,     0},
		'{1, REG_MU,     Q_MAX,       Q_MAX,        0, 0, 0,     0},
		'{1, REG_COUPLE, Q_MAX,       Q_MIN,        1, 0, 0,     0}
	};

	// ---------------------------------------------------------------- main
	initial begin
		int sent, run_len;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].wr) begin
				drain();
				write_reg(plan[i].reg_id, plan[i].wval);
			end
			send_sample(plan[i].smp, plan[i].fin);
			if (plan[i].typed) begin
				// the point just queued is this row's final point
				pending_pts[pending_pts.size() - 1].result = q_t'(plan[i].tres);
				pending_pts[pending_pts.size() - 1].sat    = plan[i].tsat;
			end
		end

		// random phases: new settings, then a handful of runs
		sent = 0;
		drain();
		write_reg(REG_STEP, ONE / 8);
		write_reg(REG_LEFT, 0);
		write_reg(REG_KINV, 64 * ONE);
		write_reg(REG_COUPLE, ONE / 4);
		write_reg(REG_MU, ONE);
		// overlong run: no final marker, the block cuts it at MAX_POINTS
		repeat (MAX_POINTS + 6) begin
			send_sample(longint'($urandom_range(0, 32'h0200_0000)) - 64'sh0100_0000, 0);
			sent++;
		end
		send_sample(ONE, 1);
		sent++;
		while (sent < N_ITEMS) begin
			drain();
			random_setup();
			repeat ($urandom_range(2, 6)) begin
				run_len = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 40);
				for (int j = 0; j < run_len; j++) begin
					send_sample(rand_sample(), j == run_len - 1);
					sent++;
				end
			end
		end

		drain();
		if (errors == 0) begin
			$display("radial_gp_operator_stencil_top: match");
		end else begin
			$display("radial_gp_operator_stencil_top: mismatch");
		end
		$finish;
	end

endmodule

>>> radial_gp_operator_stencil_top.f
design/rgos_pkg.sv
design/rgos_mul.sv
design/rgos_div.sv
design/radial_gp_operator_stencil_top.sv
sim/radial_gp_operator_stencil_top_tb.sv
